// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the tilt filter.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define TCF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tcf assertion failed");
// Condition in one cycle implies a consequence in the next.
`define TCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcf assertion failed");
`endif

// ===== hw/rtl/tcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and tables of the tilt complementary filter.
// No dependencies.
package tcf_pkg;
   localparam int VEC_W     = 28;   // CORDIC x/y datapath
   localparam int Z_W       = 30;   // angle accumulator, degrees * 2^20
   localparam int ZFRAC     = 20;
   localparam int TAB_LEN   = 24;
   localparam int CNT_W     = 5;
   localparam int RAD_W     = 48;   // (ay^2 + az^2) << 16
   localparam int ROOT_W    = 24;
   localparam int MIX_W     = 58;   // blend accumulator
   localparam int WGT_W     = 17;   // weight and its complement
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GYRO_GAIN    = 2'd1;

   localparam logic [15:0] BLEND_RESET = 16'd60948;
   localparam logic [23:0] GAIN_RESET  = 24'd6404;

   // atan(2^-i) in degrees * 2^20
   localparam logic signed [Z_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
      30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
      30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
      30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
      30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
      30'sd917,      30'sd458,      30'sd229,      30'sd115,
      30'sd57,       30'sd29,       30'sd14,       30'sd7
   };

   localparam logic signed [Z_W-1:0] DEG180 = 30'sd188743680;
endpackage

// ===== hw/rtl/tcf_cordic.sv =====
`timescale 1ns / 1ps
// Iterative CORDIC vectoring unit: atan2(y, x), one micro-rotation per cycle.
// Depends on tcf_pkg.
module tcf_cordic import tcf_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VEC_W-1:0] y_in,
   input  logic signed [VEC_W-1:0] x_in,
   output logic signed [Z_W-1:0]   z_out,
   output logic                    done
);
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [VEC_W-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic signed [VEC_W-1:0] xs, ys;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         if (x_in < 0) begin
            // left half plane: rotate by 180 first
            z_in    = (y_in < 0) ? -DEG180 : DEG180;
            x_in_nx = -x_in;
            y_in_nx = -y_in;
         end else begin
            z_in    = '0;
            x_in_nx = x_in;
            y_in_nx = y_in;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_nx = x_ff + ys;
            y_in_nx = y_ff - xs;
            z_in    = z_ff + ATAN_TAB[cnt_ff];
         end else begin
            x_in_nx = x_ff - ys;
            y_in_nx = y_ff + xs;
            z_in    = z_ff - ATAN_TAB[cnt_ff];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in_nx;
      y_ff <= y_in_nx;
      z_ff <= z_in;
   end

   assign z_out = z_ff;
   assign done  = done_ff;
endmodule

// ===== hw/rtl/tcf_isqrt.sv =====
`timescale 1ns / 1ps
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle.
// Depends on tcf_pkg.
module tcf_isqrt import tcf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W+2:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ROOT_W+2:0]   rem_sh, trial;

   assign rem_sh = {rem_ff[ROOT_W:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

// ===== hw/rtl/tcf_blend.sv =====
`timescale 1ns / 1ps
// Complementary blend of one axis: bit-serial weighting of the gyro and accel paths,
// then round and saturate. Depends on tcf_pkg.
module tcf_blend import tcf_pkg::*; #(
   parameter int ANGLE_FRACTION_BITS = 8,
   parameter int EST_W = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [EST_W-1:0] est,
   input  logic signed [15:0]      gyro,
   input  logic signed [EST_W-1:0] angle,
   input  logic [15:0]             weight,
   input  logic [23:0]             gain,
   output logic signed [EST_W-1:0] result,
   output logic                    done
);
   localparam int UP_SH  = 24 - ANGLE_FRACTION_BITS;
   localparam int OUT_SH = 40 - ANGLE_FRACTION_BITS;
   localparam logic signed [MIX_W-1:0] HALF  = MIX_W'(1) <<< (OUT_SH - 1);
   localparam logic signed [MIX_W-1:0] LIMIT = MIX_W'(360) <<< ANGLE_FRACTION_BITS;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [MIX_W-1:0] sum_ff, sum_in, acc_ff, acc_in, mix_ff, mix_in;
   logic [WGT_W-1:0]        w_ff, w_in, wc_ff, wc_in;
   logic signed [40:0]      prod;
   logic signed [MIX_W-1:0] rnd, sat;

   assign prod = gyro * $signed({1'b0, gain});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      acc_in  = acc_ff;
      mix_in  = mix_ff;
      w_in    = w_ff;
      wc_in   = wc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sum_in  = (MIX_W'(est) <<< UP_SH) + MIX_W'(prod);
         acc_in  = MIX_W'(angle) <<< UP_SH;
         mix_in  = '0;
         w_in    = {1'b0, weight};
         wc_in   = 17'd65536 - {1'b0, weight};
      end else if (busy_ff) begin
         // one weight bit per cycle, LSB first
         mix_in = mix_ff + (w_ff[0] ? sum_ff : '0) + (wc_ff[0] ? acc_ff : '0);
         sum_in = sum_ff <<< 1;
         acc_in = acc_ff <<< 1;
         w_in   = w_ff >> 1;
         wc_in  = wc_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WGT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sum_ff <= sum_in;
      acc_ff <= acc_in;
      mix_ff <= mix_in;
      w_ff   <= w_in;
      wc_ff  <= wc_in;
   end

   always_comb begin
      rnd = (mix_ff + HALF) >>> OUT_SH;
      if (rnd > LIMIT) begin
         sat = LIMIT;
      end else if (rnd < -LIMIT) begin
         sat = -LIMIT;
      end else begin
         sat = rnd;
      end
   end

   assign result = EST_W'(sat);
   assign done   = done_ff;
endmodule

// ===== hw/rtl/tilt_complementary_filter.sv =====
`timescale 1ns / 1ps
// Tilt estimator: accelerometer roll/pitch by CORDIC, fused with integrated gyro rates.
// Depends on tcf_pkg, tcf_cordic, tcf_isqrt, tcf_blend, assert_macros.svh.
//
// Usage:
//   req_* carries one sensor item (accel x/y/z, gyro x/y); rsp_* returns one result
//   item (accel roll/pitch, fused roll/pitch) per input item, in order.
//   csr_* writes blend_weight (index 0) or gyro_step_gain (index 1) while idle.
// Sequence from accept to rsp_tvalid: a load state, the bit-serial square root (roll
//   CORDIC runs alongside), the pitch CORDIC, the bit-serial blend with its result
//   capture, and the output load.
// Items: taken one at a time. The square root and the serial blend multiplier take
//   most of the time per item.
// Stall: the result sits in the output register until rsp_tready; the next item may
//   be accepted meanwhile, and its result waits for the register to free up.
// Reset: synchronous; clears both estimates to zero and loads the register defaults.
`include "assert_macros.svh"
module tilt_complementary_filter import tcf_pkg::*; #(
   parameter int CORDIC_ITERATIONS   = 16,
   parameter int ANGLE_FRACTION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48], gyro_y[79:64]
   input  logic [79:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // accel_roll[16:0], accel_pitch[32:17], fused_roll[50:33], fused_pitch[68:51], zero pad
   output logic [71:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);
   localparam int EST_W = ANGLE_FRACTION_BITS + 10;
   localparam int DS    = ZFRAC - ANGLE_FRACTION_BITS;
   localparam logic signed [Z_W-1:0] ZHALF = Z_W'(1) <<< (DS - 1);
   localparam logic signed [Z_W-1:0] LIM_R = Z_W'(180) <<< ANGLE_FRACTION_BITS;
   localparam logic signed [Z_W-1:0] LIM_P = Z_W'(90) <<< ANGLE_FRACTION_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_MAG   = 3'd2;
   localparam logic [2:0] S_PITCH = 3'd3;
   localparam logic [2:0] S_FUSE  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [15:0]             weight_ff;
   logic [23:0]             gain_ff;
   logic signed [15:0]      ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic [31:0]             sq;
   logic signed [31:0]      ay2, az2;
   logic signed [EST_W-1:0] roll_est_ff, pitch_est_ff;
   logic signed [EST_W-1:0] roll_ang_ff, pitch_ang_ff;
   logic signed [EST_W-1:0] fr_ff, fp_ff;
   logic                    rsp_valid_ff;
   logic [71:0]             rsp_data_ff;

   logic                    accept, out_free;
   logic                    roll_start, pitch_start, blend_start;
   logic                    roll_done, pitch_done, sqrt_done, roll_bl_done, pitch_bl_done;
   logic signed [Z_W-1:0]   roll_z, pitch_z, roll_r, pitch_r;
   logic signed [EST_W-1:0] roll_ang_c, pitch_ang_c, fr_c, fp_c;
   logic [ROOT_W-1:0]       mag;
   logic                    roll_zero, pitch_zero;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign roll_start  = (state_ff == S_LOAD);
   assign pitch_start = (state_ff == S_MAG) && sqrt_done;
   assign blend_start = (state_ff == S_PITCH) && pitch_done;

   assign ay2 = ay_ff * ay_ff;
   assign az2 = az_ff * az_ff;
   assign sq  = 32'(ay2) + 32'(az2);

   assign roll_zero  = (ay_ff == 16'sd0) && (az_ff == 16'sd0);
   assign pitch_zero = roll_zero && (ax_ff == 16'sd0);

   tcf_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_roll_cordic (
      .clock (clock), .reset (reset), .start (roll_start),
      .y_in  (VEC_W'(ay_ff) <<< 8), .x_in (VEC_W'(az_ff) <<< 8),
      .z_out (roll_z), .done (roll_done)
   );

   tcf_isqrt u_isqrt (
      .clock (clock), .reset (reset), .start (roll_start),
      .radicand ({sq, 16'd0}), .root (mag), .done (sqrt_done)
   );

   tcf_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_pitch_cordic (
      .clock (clock), .reset (reset), .start (pitch_start),
      .y_in  (-(VEC_W'(ax_ff) <<< 8)), .x_in (VEC_W'(mag)),
      .z_out (pitch_z), .done (pitch_done)
   );

   // round half up to angle units, clamp, and zero for a null vector
   always_comb begin
      roll_r = (roll_z + ZHALF) >>> DS;
      if (roll_r > LIM_R) begin
         roll_r = LIM_R;
      end else if (roll_r < -LIM_R) begin
         roll_r = -LIM_R;
      end
      pitch_r = (pitch_z + ZHALF) >>> DS;
      if (pitch_r > LIM_P) begin
         pitch_r = LIM_P;
      end else if (pitch_r < -LIM_P) begin
         pitch_r = -LIM_P;
      end
      roll_ang_c  = roll_zero ? '0 : EST_W'(roll_r);
      pitch_ang_c = pitch_zero ? '0 : EST_W'(pitch_r);
   end

   tcf_blend #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .EST_W(EST_W)) u_roll_blend (
      .clock (clock), .reset (reset), .start (blend_start),
      .est (roll_est_ff), .gyro (gx_ff), .angle (roll_ang_ff),
      .weight (weight_ff), .gain (gain_ff), .result (fr_c), .done (roll_bl_done)
   );

   tcf_blend #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .EST_W(EST_W)) u_pitch_blend (
      .clock (clock), .reset (reset), .start (blend_start),
      .est (pitch_est_ff), .gyro (gy_ff), .angle (pitch_ang_c),
      .weight (weight_ff), .gain (gain_ff), .result (fp_c), .done (pitch_bl_done)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_LOAD;
         S_LOAD:  state_in = S_MAG;
         S_MAG:   if (sqrt_done) state_in = S_PITCH;
         S_PITCH: if (pitch_done) state_in = S_FUSE;
         S_FUSE:  if (roll_bl_done) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         weight_ff    <= BLEND_RESET;
         gain_ff      <= GAIN_RESET;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == REG_BLEND_WEIGHT) begin
            weight_ff <= csr_wdata[15:0];
         end
         if (csr_we && csr_index == REG_GYRO_GAIN) begin
            gain_ff <= csr_wdata[23:0];
         end
         if (state_ff == S_OUT && out_free) begin
            roll_est_ff  <= fr_ff;
            pitch_est_ff <= fp_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         gx_ff <= req_tdata[63:48];
         gy_ff <= req_tdata[79:64];
      end
      if (roll_done) begin
         roll_ang_ff <= roll_ang_c;
      end
      if (blend_start) begin
         pitch_ang_ff <= pitch_ang_c;
      end
      if (roll_bl_done) begin
         fr_ff <= fr_c;
         fp_ff <= fp_c;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= {3'd0, 18'(fp_ff), 18'(fr_ff), 16'(pitch_ang_ff), 17'(roll_ang_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TCF_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff) == S_OUT)
   `TCF_ASSERT_NEXT(a_est_hold, clock, reset, state_ff != S_OUT, $stable(roll_est_ff) && $stable(pitch_est_ff))
   `TCF_ASSERT(a_blend_lockstep, clock, reset, roll_bl_done == pitch_bl_done)
endmodule

// ===== tb/tcf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for tilt_complementary_filter: predicts the result item of every
// accepted sensor item and compares it with the returned item. Depends on tcf_pkg.
module tcf_checker import tcf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [79:0]          req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [71:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatches,
   output int                   pending
);
   typedef struct packed {
      logic [17:0] fused_pitch;
      logic [17:0] fused_roll;
      logic [15:0] accel_pitch;
      logic [16:0] accel_roll;
   } tilt_result_type;

   localparam int ATAN_DEG [0:15] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
   };

   tilt_result_type expected_tilt[$];
   logic [15:0]  blend_w;
   logic [23:0]  step_gain;
   longint       roll_est, pitch_est;

   function automatic longint rnd_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clampl(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // angle of (x, y) in degrees * 2^20
   function automatic longint vector_angle(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      if (x < 0) begin
         z = (y < 0) ? -(64'sd180 <<< 20) : (64'sd180 <<< 20);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ATAN_DEG[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= ATAN_DEG[i];
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic longint blend_angle(longint est, longint rate, longint ang);
      longint sum, mix, w;
      w = longint'(blend_w);
      sum = est * 65536 + rate * longint'(step_gain);
      mix = sum * w + ang * 65536 * (65536 - w);
      return clampl(rnd_shr(mix, 32), 64'sd360 <<< 8);
   endfunction

   always @(posedge clock) begin : predict_and_compare
      longint ax, ay, az, gx, gy, roll, pitch, mag, fr, fp;
      tilt_result_type got, want;
      if (reset) begin
         blend_w = BLEND_RESET;
         step_gain = GAIN_RESET;
         roll_est = 0;
         pitch_est = 0;
         expected_tilt.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_BLEND_WEIGHT) blend_w = csr_wdata[15:0];
            else if (csr_index == REG_GYRO_GAIN) step_gain = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            ax = longint'($signed(req_tdata[15:0]));
            ay = longint'($signed(req_tdata[31:16]));
            az = longint'($signed(req_tdata[47:32]));
            gx = longint'($signed(req_tdata[63:48]));
            gy = longint'($signed(req_tdata[79:64]));
            roll = 0;
            pitch = 0;
            if (ay != 0 || az != 0)
               roll = clampl(rnd_shr(vector_angle(ay * 256, az * 256), 12), 64'sd180 <<< 8);
            mag = int_sqrt(longint'(ay * ay + az * az) << 16);
            if (ax != 0 || mag != 0)
               pitch = clampl(rnd_shr(vector_angle(-ax * 256, mag), 12), 64'sd90 <<< 8);
            fr = blend_angle(roll_est, gx, roll);
            fp = blend_angle(pitch_est, gy, pitch);
            roll_est = fr;
            pitch_est = fp;
            want.accel_roll = roll[16:0];
            want.accel_pitch = pitch[15:0];
            want.fused_roll = fr[17:0];
            want.fused_pitch = fp[17:0];
            expected_tilt.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[68:0];
            if (expected_tilt.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result item %h", $realtime, got);
            end else begin
               want = expected_tilt.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: roll/pitch/fr/fp exp %h %h %h %h got %h %h %h %h",
                        $realtime, want.accel_roll, want.accel_pitch, want.fused_roll,
                        want.fused_pitch, got.accel_roll, got.accel_pitch,
                        got.fused_roll, got.fused_pitch);
               end
            end
         end
      end
      pending = expected_tilt.size();
   end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the tilt filter testbench: clock, reset, sensor item stimulus,
// register settings and verdict. Depends on tcf_pkg, tcf_checker, the RTL.
module testbench;
   import tcf_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [71:0]          rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   int                   mismatches, pending;
   bit                   no_idle = 1'b0;
   bit                   hold_go = 1'b0;
   int                   hold_cnt = 0;
   int                   cycles = 0;

   tilt_complementary_filter uut (.*);
   tcf_checker scoreboard (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (hold_go && hold_cnt < 600) begin
         hold_cnt++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 24);
      end
   end

   task automatic send_item(logic signed [15:0] ax, ay, az, gx, gy);
      if (!no_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 24);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {gy, gx, az, ay, ax};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
   endtask

   task automatic drain_and_set(logic [15:0] weight, logic [23:0] gain);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_write(REG_BLEND_WEIGHT, {8'($urandom), weight});
      csr_write(REG_GYRO_GAIN, gain);
      csr_write(2'd2, 24'($urandom));
      csr_write(2'd3, 24'($urandom));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_axis(bit tame);
      if (tame) return 16'($signed($urandom_range(36000)) - 18000);
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_items(int count);
      bit tame;
      for (int i = 0; i < count; i++) begin
         tame = $urandom_range(99) < 60;
         send_item(rand_axis(tame), rand_axis(tame), rand_axis(tame),
                   rand_axis(tame), rand_axis(tame));
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero vectors, axis extremes, both half planes of the roll angle
      send_item(0, 0, 0, 0, 0);
      send_item(100, 0, 0, 0, 0);
      send_item(-100, 0, 0, 0, 0);
      send_item(-32768, 0, 0, 32767, -32768);
      send_item(32767, 0, 0, -32768, 32767);
      send_item(0, 16384, 0, 0, 0);
      send_item(0, -16384, 0, 0, 0);
      send_item(0, 0, 16384, 0, 0);
      send_item(0, 0, -16384, 0, 0);
      send_item(0, 1, -16384, 0, 0);
      send_item(0, -1, -16384, 0, 0);
      send_item(0, 0, -1, 0, 0);
      send_item(-32768, -32768, -32768, -32768, -32768);
      send_item(32767, 32767, 32767, 32767, 32767);
      send_item(-32768, 32767, -32768, 1, -1);
      send_item(5000, -32768, 32767, 100, -100);
      send_item(-1, -1, -1, -1, -1);
      send_item(1, 1, 1, 1, 1);
      random_items(300);

      // long hold-off on the result side while items keep coming
      hold_go = 1'b1;
      random_items(150);

      drain_and_set(16'd65535, 24'hffffff);
      no_idle = 1'b1;
      send_item(0, 0, 16384, 32767, 32767);
      send_item(0, 0, 16384, 32767, 32767);
      send_item(0, 0, 16384, -32768, -32768);
      send_item(0, 0, 16384, -32768, -32768);
      random_items(250);
      no_idle = 1'b0;

      drain_and_set(16'd0, 24'd0);
      random_items(250);

      drain_and_set(16'd32768, 24'd6404);
      random_items(250);

      drain_and_set(16'($urandom), 24'($urandom));
      random_items(250);

      drain_and_set(BLEND_RESET, GAIN_RESET);
      random_items(180);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_cordic.sv
hw/rtl/tcf_isqrt.sv
hw/rtl/tcf_blend.sv
hw/rtl/tilt_complementary_filter.sv
tb/tcf_checker.sv
tb/testbench.sv
